### sv/csfw_pkg.sv
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared types and constants for the counting semaphore with a FIFO of
// waiting thread ids.
// ----------------------------------------------------------------------------
package csfw_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 8;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int TOTAL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W       = 16;
  localparam int INIT_W      = 15;

  localparam logic signed [CNT_W-1:0] COUNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] COUNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  typedef enum logic {
    CMD_WAIT = 1'b0,
    CMD_POST = 1'b1
  } sem_cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BLOCKED   = 2'd1,
    STAT_NO_THREAD = 2'd2,
    STAT_FULL      = 2'd3
  } sem_status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_state_t;

  typedef struct packed {
    sem_cmd_t              cmd;
    logic                  caller_present;
    logic [ID_WIDTH-1:0]   caller_id;
  } in_item_t;

  typedef struct packed {
    sem_status_t           status;
    logic                  wake_valid;
    logic [ID_WIDTH-1:0]   wake_id;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_cmd_t;

  typedef struct packed {
    logic queue_empty;
    logic queue_full;
  } dp_status_t;

endpackage

### sv/counting_semaphore_fifo_waiters.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters
// Counting semaphore with a FIFO of waiting thread ids.
//
//   Channel   Handshake             Payload
//   input     start / busy          in_item   (cmd, caller_present, caller_id)
//   result    out_strobe            out_item  (status, wake_valid, wake_id)
//   config    cfg_we                cfg_wdata (initial_count)
//
// A transaction is captured, with the queue head read from the id memory, and
// then executed, which updates the count and pointers. The result strobe
// rises in the following cycle, when busy is already low again, so a new
// transaction may start while the previous result is shown. Reset loads a
// count of zero and an empty queue. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  csfw_pkg::in_item_t            in_item,
  output logic                          out_strobe,
  output csfw_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [csfw_pkg::INIT_W-1:0]   cfg_wdata
);
  import csfw_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t sts;

  csfw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  csfw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item),
    .sts       (sts)
  );

`ifndef NO_ASSERTIONS
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted transaction did not enter execution.");

  a_busy_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_strobe && !busy))
    else $error("Execution step did not produce exactly one result.");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.queue_empty && sts.queue_full))
    else $error("Waiter queue reports empty and full at once.");

  a_wake_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.wake_valid) |-> (out_item.status == STAT_OK))
    else $error("Woken thread reported with a non-ok status.");
`endif

endmodule

### sv/csfw_ctrl.sv
// ----------------------------------------------------------------------------
// csfw_ctrl
// Sequencer: takes a transaction, runs one execute step in the datapath and
// raises the result strobe for one cycle.
// ----------------------------------------------------------------------------
module csfw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_strobe,
  output csfw_pkg::ctl_cmd_t  cmd
);
  import csfw_pkg::*;

  fsm_state_t state_r;
  fsm_state_t state_nxt;
  logic       strobe_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (start) begin
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        state_nxt = FSM_IDLE;
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        cmd.capture = start;
      end
      FSM_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FSM_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= cmd.execute;
    end
  end

  assign out_strobe = strobe_r;

endmodule

### sv/csfw_dp.sv
// ----------------------------------------------------------------------------
// csfw_dp
// Datapath: semaphore count, waiter id memory with head and tail pointers,
// and the result register.
// ----------------------------------------------------------------------------
module csfw_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csfw_pkg::ctl_cmd_t            cmd,
  input  csfw_pkg::in_item_t            in_item,
  input  logic                          cfg_we,
  input  logic [csfw_pkg::INIT_W-1:0]   cfg_wdata,
  output csfw_pkg::out_item_t           out_item,
  output csfw_pkg::dp_status_t          sts
);
  import csfw_pkg::*;

  logic [ID_WIDTH-1:0]     mem [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0]     head_data_r;

  in_item_t                item_r;
  out_item_t               res_r;
  out_item_t               res_nxt;

  logic signed [CNT_W-1:0] count_r;
  logic signed [CNT_W-1:0] count_nxt;
  logic [PTR_W-1:0]        head_r;
  logic [PTR_W-1:0]        head_nxt;
  logic [PTR_W-1:0]        tail_r;
  logic [PTR_W-1:0]        tail_nxt;
  logic [TOTAL_W-1:0]      total_r;
  logic [TOTAL_W-1:0]      total_nxt;

  logic signed [CNT_W-1:0] count_dec;
  logic signed [CNT_W-1:0] count_inc;
  logic                    full;
  logic                    empty;
  logic                    push;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign full  = (total_r == TOTAL_W'(QUEUE_DEPTH));
  assign empty = (total_r == '0);

  assign count_dec = (count_r != COUNT_MIN) ? count_r - CNT_W'(1) : count_r;
  assign count_inc = (count_r != COUNT_MAX) ? count_r + CNT_W'(1) : count_r;

  always_comb begin
    count_nxt  = count_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    total_nxt  = total_r;
    push       = 1'b0;
    res_nxt.status     = STAT_OK;
    res_nxt.wake_valid = 1'b0;
    res_nxt.wake_id    = '0;
    case (item_r.cmd)
      CMD_WAIT: begin
        count_nxt = count_dec;
        if (count_dec >= 0) begin
          res_nxt.status = STAT_OK;
        end else if (!item_r.caller_present) begin
          res_nxt.status = STAT_NO_THREAD;
        end else if (full) begin
          count_nxt      = count_r;
          res_nxt.status = STAT_FULL;
        end else begin
          push           = 1'b1;
          tail_nxt       = next_slot(tail_r);
          total_nxt      = total_r + TOTAL_W'(1);
          res_nxt.status = STAT_BLOCKED;
        end
      end
      CMD_POST: begin
        count_nxt = count_inc;
        if ((count_inc <= 0) && !empty) begin
          res_nxt.wake_valid = 1'b1;
          res_nxt.wake_id    = head_data_r;
          head_nxt           = next_slot(head_r);
          total_nxt          = total_r - TOTAL_W'(1);
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r      <= in_item;
      head_data_r <= mem[head_r];
    end
    if (cmd.execute && push) begin
      mem[tail_r] <= item_r.caller_id;
    end
    if (cmd.execute) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      total_r <= '0;
    end else if (cfg_we) begin
      count_r <= signed'({1'b0, cfg_wdata});
      head_r  <= '0;
      tail_r  <= '0;
      total_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      total_r <= total_nxt;
    end
  end

  assign out_item        = res_r;
  assign sts.queue_empty = empty;
  assign sts.queue_full  = full;

endmodule
